// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion held off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also covers reset cycles.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tcvc_pkg.sv =====
// Types and constants of the triangle cull / vertex compactor.
// Used by every module of the block but the RAM; depends on nothing.
package tcvc_pkg;

  localparam int IDX_W     = 12;
  localparam int TC_W      = 32;
  localparam int MASK_W    = 4;
  localparam int COUNT_W   = 13;
  localparam int EPOCH_W   = 8;
  localparam int CULL_BITS = 4;

  localparam int TABLE_LIMIT = 1 << IDX_W;

  localparam logic [MASK_W-1:0] CULL_MASK =
    (CULL_BITS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << CULL_BITS) - 1);

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  // corner position within a triangle
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef struct packed {
    logic              surface_start;
    logic [IDX_W-1:0]  src_index_a;
    logic [IDX_W-1:0]  src_index_b;
    logic [IDX_W-1:0]  src_index_c;
    logic [MASK_W-1:0] cull_mask_a;
    logic [MASK_W-1:0] cull_mask_b;
    logic [MASK_W-1:0] cull_mask_c;
    logic [TC_W-1:0]   tex_coord_a;
    logic [TC_W-1:0]   tex_coord_b;
    logic [TC_W-1:0]   tex_coord_c;
  } tri_item_t;

  typedef struct packed {
    logic             is_new_vertex;
    logic [IDX_W-1:0] source_vertex;
    logic [TC_W-1:0]  vertex_tex_coord;
    logic [IDX_W-1:0] compact_index;
    logic             last_of_triangle;
  } res_item_t;

  // remap RAM word: entry is mapped when tag equals the current epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [IDX_W-1:0]   compact;
  } remap_word_t;

  // one corner (or a clear-only slot) moving from issue to resolve
  typedef struct packed {
    logic               valid;
    logic               has_corner;
    logic               clear;
    logic               in_range;
    logic               last;
    logic [EPOCH_W-1:0] epoch;
    logic [IDX_W-1:0]   idx;
    logic [TC_W-1:0]    tc;
  } slot_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    remap_word_t      word;
  } wr_req_t;

endpackage

// ===== src/tcvc_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// Depends on nothing.
module tcvc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcvc_issue.sv =====
// Input side: triangle accept, corner sequencer, epoch and RAM clearing sweep.
// Depends on tcvc_pkg.
module tcvc_issue #(
  parameter int MAX_SOURCE_VERTS = 4096,
  parameter int DEPTH            = 4096,
  parameter int AW               = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tri_valid,
  input  tcvc_pkg::tri_item_t  tri_item,
  output logic                 tri_stall,
  input  logic                 issue_ok,
  input  logic                 s1_busy,
  output tcvc_pkg::slot_t      slot,
  output tcvc_pkg::rd_req_t    rd,
  output tcvc_pkg::wr_req_t    sweep_wr
);

  typedef enum logic {ST_SWEEP, ST_RUN} state_t;

  localparam logic [16:0]   MAX_V     = 17'(MAX_SOURCE_VERTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  state_t                            state;
  logic                              busy;
  logic                              culled;
  logic [1:0]                        corner;
  tcvc_pkg::tri_item_t               tri_r;
  logic [tcvc_pkg::EPOCH_W-1:0]      epoch;
  logic [AW-1:0]                     sweep_addr;

  logic                              issue_fire;
  logic                              last_fire;
  logic                              need_sweep;
  logic                              can_take;
  logic                              accept;
  logic                              cur_in_range;
  logic [tcvc_pkg::IDX_W-1:0]        cur_idx;
  logic [tcvc_pkg::TC_W-1:0]         cur_tc;

  always_comb begin
    case (corner)
      tcvc_pkg::CORNER_A: begin
        cur_idx = tri_r.src_index_a;
        cur_tc  = tri_r.tex_coord_a;
      end
      tcvc_pkg::CORNER_B: begin
        cur_idx = tri_r.src_index_b;
        cur_tc  = tri_r.tex_coord_b;
      end
      default: begin
        cur_idx = tri_r.src_index_c;
        cur_tc  = tri_r.tex_coord_c;
      end
    endcase
  end

  assign cur_in_range = ({5'd0, cur_idx} < MAX_V);

  assign issue_fire = (state == ST_RUN) && busy && issue_ok;
  assign last_fire  = issue_fire && (culled || (corner == tcvc_pkg::CORNER_C));
  // epoch space exhausted: drain and sweep before taking the next surface
  assign need_sweep = tri_valid && tri_item.surface_start && (epoch == tcvc_pkg::EPOCH_MAX);
  assign can_take   = (state == ST_RUN) && (!busy || last_fire) && !need_sweep;
  assign accept     = tri_valid && can_take;
  assign tri_stall  = !can_take;

  always_comb begin
    slot.valid      = issue_fire;
    slot.has_corner = !culled;
    slot.clear      = tri_r.surface_start && (corner == tcvc_pkg::CORNER_A);
    slot.in_range   = cur_in_range;
    slot.last       = (corner == tcvc_pkg::CORNER_C);
    slot.epoch      = epoch;
    slot.idx        = cur_idx;
    slot.tc         = cur_tc;

    rd.re   = issue_fire && !culled && cur_in_range;
    rd.addr = cur_idx;

    sweep_wr.we   = (state == ST_SWEEP);
    sweep_wr.addr = tcvc_pkg::IDX_W'(sweep_addr);
    sweep_wr.word = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      epoch      <= '0;
      busy       <= 1'b0;
      corner     <= tcvc_pkg::CORNER_A;
    end else begin
      case (state)
        ST_SWEEP: begin
          if (sweep_addr == LAST_ADDR) begin
            sweep_addr <= '0;
            state      <= ST_RUN;
            epoch      <= epoch + 1'b1;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        ST_RUN: begin
          if (need_sweep && !busy && !s1_busy) begin
            state <= ST_SWEEP;
          end
          if (issue_fire) begin
            corner <= last_fire ? tcvc_pkg::CORNER_A : corner + 1'b1;
          end
          if (last_fire && !accept) begin
            busy <= 1'b0;
          end
          if (accept) begin
            busy   <= 1'b1;
            tri_r  <= tri_item;
            culled <= |(tri_item.cull_mask_a & tri_item.cull_mask_b &
                        tri_item.cull_mask_c & tcvc_pkg::CULL_MASK);
            if (tri_item.surface_start) begin
              epoch <= epoch + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

endmodule

// ===== src/tcvc_resolve.sv =====
// Lookup resolve stage: RAM data with write forwarding, compact numbering.
// Depends on tcvc_pkg.
module tcvc_resolve (
  input  logic                   clk,
  input  logic                   rst,
  input  tcvc_pkg::slot_t        slot,
  input  tcvc_pkg::remap_word_t  rdata,
  output tcvc_pkg::wr_req_t      wr,
  output logic                   res_push,
  output tcvc_pkg::res_item_t    res_item,
  output logic                   s1_busy
);

  tcvc_pkg::slot_t                s1;
  logic                           fwd_hit;
  tcvc_pkg::remap_word_t          fwd_word;
  logic [tcvc_pkg::COUNT_W-1:0]   vertex_count;

  logic [tcvc_pkg::COUNT_W-1:0]   count_eff;
  logic [tcvc_pkg::COUNT_W-1:0]   vertex_count_next;
  tcvc_pkg::remap_word_t          word;
  logic                           mapped;
  logic                           is_new;
  logic [tcvc_pkg::IDX_W-1:0]     compact;

  always_comb begin
    count_eff         = s1.clear ? '0 : vertex_count;
    word              = fwd_hit ? fwd_word : rdata;
    mapped            = (word.tag == s1.epoch);
    is_new            = 1'b0;
    compact           = '0;
    vertex_count_next = count_eff;
    wr.we             = 1'b0;
    wr.addr           = s1.idx;
    wr.word.tag       = s1.epoch;
    wr.word.compact   = count_eff[tcvc_pkg::IDX_W-1:0];
    if (s1.has_corner && s1.in_range) begin
      if (mapped) begin
        compact = word.compact;
      end else if (!count_eff[tcvc_pkg::COUNT_W-1]) begin
        is_new            = 1'b1;
        compact           = count_eff[tcvc_pkg::IDX_W-1:0];
        wr.we             = s1.valid;
        vertex_count_next = count_eff + 1'b1;
      end else begin
        // compact space full
        compact = '1;
      end
    end
  end

  assign res_push = s1.valid && s1.has_corner;
  assign s1_busy  = s1.valid;

  always_comb begin
    res_item.is_new_vertex    = is_new;
    res_item.source_vertex    = s1.idx;
    res_item.vertex_tex_coord = is_new ? s1.tc : '0;
    res_item.compact_index    = compact;
    res_item.last_of_triangle = s1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1           <= '0;
      fwd_hit      <= 1'b0;
      vertex_count <= '0;
    end else begin
      s1 <= slot;
      // RAM read of the same entry written this edge returns old data
      fwd_hit <= slot.valid && wr.we && (wr.addr == slot.idx);
      if (s1.valid) begin
        vertex_count <= vertex_count_next;
      end
    end
    fwd_word <= wr.word;
  end

endmodule

// ===== src/tcvc_outq.sv =====
// Two-entry result queue with issue credit for the RAM pipeline.
// Depends on tcvc_pkg.
module tcvc_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tcvc_pkg::res_item_t  push_item,
  input  logic                 inflight,
  output logic                 issue_ok,
  output logic                 res_valid,
  input  logic                 res_stall,
  output tcvc_pkg::res_item_t  res_item
);

  localparam logic [2:0] QDEPTH = 3'd2;

  tcvc_pkg::res_item_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                pop;

  assign res_valid = (count != 2'd0);
  assign res_item  = entries[rd_ptr];
  assign pop       = res_valid && !res_stall;
  assign issue_ok  = (3'(count) + 3'(inflight) - 3'(pop)) < QDEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/triangle_cull_vertex_compactor_core.sv =====
// Top level of the triangle cull / vertex index compactor.
// Depends on tcvc_pkg, tcvc_ram, tcvc_issue, tcvc_resolve, tcvc_outq.
//
// Usage:
//  - tri channel (tri_valid / tri_stall / tri_item): one triangle per item.
//    A triangle whose three cull masks share a set bit is dropped and gives
//    no result; a surface_start on it still restarts the surface.
//  - res channel (res_valid / res_stall / res_item): one item per corner of
//    a kept triangle, in corner order, last_of_triangle set on the third.
//  - Throughput: one corner per cycle through the single read and write ports
//    of the remap RAM while the result queue grants issue credit; a culled
//    triangle issues a slot with no corner. The next triangle is taken in the
//    cycle its predecessor's last corner issues.
//  - Results: each corner is registered in the resolve stage, then written
//    into the result queue, from which it shows on res_valid.
//  - Reset: the remap RAM is swept, one entry a cycle, with tri_stall high.
//    Surfaces are told apart by an epoch tag in each RAM word; every 255th
//    surface start drains the pipe and runs the same sweep before that
//    triangle is taken.
//  - Stall: res_stall holds the queued result; a two-entry result queue and
//    issue credit keep the RAM pipe from overrunning it, so tri_stall rises
//    once the queue and the pipe are full.
module triangle_cull_vertex_compactor_core #(
  parameter int MAX_SOURCE_VERTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tri_valid,
  output logic                 tri_stall,
  input  tcvc_pkg::tri_item_t  tri_item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output tcvc_pkg::res_item_t  res_item
);

  // only indices below the table limit can ever be stored
  localparam int DEPTH = (MAX_SOURCE_VERTS < tcvc_pkg::TABLE_LIMIT) ?
                         MAX_SOURCE_VERTS : tcvc_pkg::TABLE_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WORD_W = $bits(tcvc_pkg::remap_word_t);

  tcvc_pkg::slot_t        slot;
  tcvc_pkg::rd_req_t      rd;
  tcvc_pkg::wr_req_t      sweep_wr;
  tcvc_pkg::wr_req_t      res_wr;
  tcvc_pkg::res_item_t    push_item;
  logic                   push;
  logic                   s1_busy;
  logic                   issue_ok;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      ram_rdata;

  // sweep and resolve never write in the same cycle: sweep runs on a drained pipe
  assign ram_we    = sweep_wr.we || res_wr.we;
  assign ram_waddr = sweep_wr.we ? sweep_wr.addr[AW-1:0] : res_wr.addr[AW-1:0];
  assign ram_wdata = sweep_wr.we ? sweep_wr.word : res_wr.word;

  tcvc_issue #(
    .MAX_SOURCE_VERTS (MAX_SOURCE_VERTS),
    .DEPTH            (DEPTH),
    .AW               (AW)
  ) u_issue (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_item  (tri_item),
    .tri_stall (tri_stall),
    .issue_ok  (issue_ok),
    .s1_busy   (s1_busy),
    .slot      (slot),
    .rd        (rd),
    .sweep_wr  (sweep_wr)
  );

  tcvc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_remap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd.re),
    .raddr (rd.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  tcvc_resolve u_resolve (
    .clk      (clk),
    .rst      (rst),
    .slot     (slot),
    .rdata    (tcvc_pkg::remap_word_t'(ram_rdata)),
    .wr       (res_wr),
    .res_push (push),
    .res_item (push_item),
    .s1_busy  (s1_busy)
  );

  tcvc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .inflight  (s1_busy),
    .issue_ok  (issue_ok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== src/tcvc_checker.sv =====
// Port-level checks of the compactor core, bound to the top level.
// Depends on tcvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcvc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 tri_stall,
  input logic                 res_valid,
  input logic                 res_stall,
  input tcvc_pkg::res_item_t  res_item
);

  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res_item), "stalled result item changed")
  `CHK_ASSERT(a_tc_zero, clk, rst, res_valid && !res_item.is_new_vertex |-> res_item.vertex_tex_coord == '0, "tex coord on a mapped vertex")
  `CHK_ASSERT_NR(a_rst_sweep, clk, rst |=> tri_stall, "triangle taken during reset sweep")
  `CHK_ASSERT_NR(a_rst_empty, clk, rst |=> !res_valid, "result item after reset")

endmodule

bind triangle_cull_vertex_compactor_core tcvc_checker u_tcvc_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for triangle_cull_vertex_compactor_core: random and
// directed triangles against a local model of the cull and remap logic.
// Depends on tcvc_pkg and the core RTL only.
module tb;

  localparam int MAX_SOURCE_VERTS = 4096;
  localparam int COMPACT_SPACE    = 4096;
  localparam int QUIET_LIMIT      = 30000; // covers the RAM sweeps
  localparam int HOLD_CYCLES      = 150;
  localparam int END_CYCLES       = 16;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                tri_valid = 1'b0;
  logic                tri_stall;
  tcvc_pkg::tri_item_t tri_item = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  tcvc_pkg::res_item_t res_item;

  triangle_cull_vertex_compactor_core dut (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_item  (tri_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #5 clk = ~clk;

  // stimulus and expected corners
  tcvc_pkg::tri_item_t pending_tris[$];
  tcvc_pkg::res_item_t expected_corners[$];
  int        tris_queued = 0;
  int        tris_accepted = 0;
  logic      tri_taken = 1'b0;

  // idle percentages per phase, and the one long receiver hold-off
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;

  int        quiet_cycles = 0;
  bit        timed_out = 1'b0;
  int        mismatches = 0;

  // run statistics for the summary
  int        kept_tris = 0;
  int        culled_tris = 0;
  int        surface_starts = 0;
  int        new_vertices = 0;
  int        corners_checked = 0;

  // local model of the remap state
  bit          seen_vertex [MAX_SOURCE_VERTS];
  logic [11:0] compact_of  [MAX_SOURCE_VERTS];
  logic [12:0] next_compact = '0;

  logic [11:0] pool_base = '0;

  // ---------------------------------------------------------------------------
  // Model: one corner lookup. First sight of a source vertex in the current
  // surface hands out the next compact number and passes the tex coord.
  // ---------------------------------------------------------------------------
  function automatic tcvc_pkg::res_item_t resolve_corner(logic [11:0] idx,
                                                         logic [31:0] tc,
                                                         logic last);
    tcvc_pkg::res_item_t r;
    r = '0;
    r.source_vertex    = idx;
    r.last_of_triangle = last;
    if (int'(idx) < MAX_SOURCE_VERTS) begin
      if (seen_vertex[idx]) begin
        r.compact_index = compact_of[idx];
      end else if (next_compact < COMPACT_SPACE) begin
        r.compact_index     = next_compact[11:0];
        r.is_new_vertex     = 1'b1;
        r.vertex_tex_coord  = tc;
        compact_of[idx]     = next_compact[11:0];
        seen_vertex[idx]    = 1'b1;
        next_compact        = next_compact + 13'd1;
        new_vertices++;
      end else begin
        // compact space exhausted: vertex is not entered
        r.compact_index = '1;
      end
    end
    return r;
  endfunction

  // surface start clears before the cull test, so a culled start still clears
  task automatic predict_triangle(tcvc_pkg::tri_item_t t);
    if (t.surface_start) begin
      seen_vertex  = '{default: 1'b0};
      next_compact = '0;
      surface_starts++;
    end
    if ((t.cull_mask_a & t.cull_mask_b & t.cull_mask_c & tcvc_pkg::CULL_MASK) != '0) begin
      culled_tris++;
    end else begin
      expected_corners.push_back(resolve_corner(t.src_index_a, t.tex_coord_a, 1'b0));
      expected_corners.push_back(resolve_corner(t.src_index_b, t.tex_coord_b, 1'b0));
      expected_corners.push_back(resolve_corner(t.src_index_c, t.tex_coord_c, 1'b1));
      kept_tris++;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a new item goes out at the falling edge once the last one was
  // taken; a stalled item is held unchanged.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      tri_valid <= 1'b0;
    end else if (tri_valid && !tri_taken) begin
      // stalled, keep the payload
    end else if (pending_tris.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      tri_item  <= pending_tris.pop_front();
      tri_valid <= 1'b1;
    end else begin
      tri_valid <= 1'b0;
    end
  end

  // Receiver stall: random per phase, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted triangle, checks every accepted result
  // against the oldest expected corner, and tracks progress for the watchdog.
  // Results nobody expects do not count as progress.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tcvc_pkg::res_item_t want;
    bit                  progress;
    progress = (tri_valid && !tri_stall) ||
               (res_valid && !res_stall && expected_corners.size() != 0);
    tri_taken <= !rst && tri_valid && !tri_stall;
    if (!rst) begin
      if (tri_valid && !tri_stall) begin
        predict_triangle(tri_item);
        tris_accepted <= tris_accepted + 1;
      end
      if (res_valid && !res_stall) begin
        corners_checked++;
        if (expected_corners.size() == 0) begin
          $display("%0t unexpected result: expected none, got %p", $time, res_item);
          mismatches++;
        end else begin
          want = expected_corners.pop_front();
          check_field("is_new_vertex", want.is_new_vertex, res_item.is_new_vertex);
          check_field("source_vertex", want.source_vertex, res_item.source_vertex);
          check_field("vertex_tex_coord", want.vertex_tex_coord,
                      res_item.vertex_tex_coord);
          check_field("compact_index", want.compact_index, res_item.compact_index);
          check_field("last_of_triangle", want.last_of_triangle,
                      res_item.last_of_triangle);
        end
      end
      if (progress)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic offer(tcvc_pkg::tri_item_t t);
    pending_tris.push_back(t);
    tris_queued++;
  endtask

  function automatic tcvc_pkg::tri_item_t make_tri(logic ss, logic [11:0] a,
                                                   logic [11:0] b, logic [11:0] c,
                                                   logic [3:0] ma, logic [3:0] mb,
                                                   logic [3:0] mc, logic [31:0] ta,
                                                   logic [31:0] tb_, logic [31:0] tc);
    tcvc_pkg::tri_item_t t;
    t.surface_start = ss;
    t.src_index_a   = a;
    t.src_index_b   = b;
    t.src_index_c   = c;
    t.cull_mask_a   = ma;
    t.cull_mask_b   = mb;
    t.cull_mask_c   = mc;
    t.tex_coord_a   = ta;
    t.tex_coord_b   = tb_;
    t.tex_coord_c   = tc;
    return t;
  endfunction

  // mostly a small pool per surface so vertices get reused across triangles
  function automatic logic [11:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return pool_base + 12'($urandom_range(0, 23));
    if (r < 9)
      return 12'($urandom_range(0, 4095));
    return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
  endfunction

  function automatic tcvc_pkg::tri_item_t make_random_tri(bit force_start);
    tcvc_pkg::tri_item_t t;
    logic [3:0]          common;
    int                  r;
    t.surface_start = force_start || ($urandom_range(0, 9) == 0);
    if (t.surface_start)
      pool_base = 12'($urandom);
    t.src_index_a = pick_index();
    t.src_index_b = pick_index();
    t.src_index_c = pick_index();
    // repeated corners within one triangle
    r = $urandom_range(0, 9);
    if (r == 0)
      t.src_index_b = t.src_index_a;
    else if (r == 1)
      t.src_index_c = t.src_index_a;
    else if (r == 2)
      t.src_index_c = t.src_index_b;
    t.cull_mask_a = 4'($urandom);
    t.cull_mask_b = 4'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      // culled: force one shared outside bit
      common = 4'b0001 << $urandom_range(0, 3);
      t.cull_mask_a = t.cull_mask_a | common;
      t.cull_mask_b = t.cull_mask_b | common;
      t.cull_mask_c = 4'($urandom) | common;
    end else begin
      t.cull_mask_c = 4'($urandom) & ~(t.cull_mask_a & t.cull_mask_b);
    end
    t.tex_coord_a = $urandom;
    t.tex_coord_b = $urandom;
    t.tex_coord_c = $urandom;
    return t;
  endfunction

  // sender pause: nothing outstanding on either side
  task automatic wait_drained();
    do @(negedge clk);
    while (tris_accepted != tris_queued || expected_corners.size() != 0);
    @(posedge clk);
  endtask

  task automatic run_all();
    // reset, then the core sweeps its RAM with tri_stall high
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, repeats, every cull bit, starts on culled tris
    send_idle_pct  = 18;
    recv_stall_pct = 66;
    offer(make_tri(1'b1, 12'd0, 12'd4095, 12'd2048, 4'h0, 4'h0, 4'h0,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000));
    offer(make_tri(1'b0, 12'd4095, 12'd2048, 12'd0, 4'hF, 4'h0, 4'hF,
                   32'h1234_5678, 32'h7FFF_7FFF, 32'hFFFF_FFFF));
    offer(make_tri(1'b0, 12'd5, 12'd5, 12'd5, 4'h0, 4'h0, 4'h0,
                   32'h7FFF_7FFF, 32'h0000_0001, 32'h8000_0000));
    offer(make_tri(1'b0, 12'd7, 12'd8, 12'd7, 4'h3, 4'h5, 4'h6,
                   32'hAAAA_5555, 32'h5555_AAAA, 32'h0F0F_F0F0));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'hF, 4'hF, 4'hF,
                   32'hDEAD_BEEF, 32'h0, 32'h1));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'h1, 4'h3, 4'h5,
                   32'h1, 32'h2, 32'h3));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'h2, 4'h6, 4'hA,
                   32'h1, 32'h2, 32'h3));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'h4, 4'hC, 4'h4,
                   32'h1, 32'h2, 32'h3));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'h8, 4'h9, 4'hF,
                   32'h1, 32'h2, 32'h3));
    offer(make_tri(1'b0, 12'd9, 12'd10, 12'd11, 4'hF, 4'hF, 4'h0,
                   32'h0001_0002, 32'h0003_0004, 32'h0005_0006));
    // culled surface start still restarts numbering
    offer(make_tri(1'b1, 12'd0, 12'd1, 12'd2, 4'h8, 4'h8, 4'h8,
                   32'h0, 32'h0, 32'h0));
    offer(make_tri(1'b0, 12'd2048, 12'd0, 12'd4095, 4'h0, 4'h1, 4'h2,
                   32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_7FFF));
    offer(make_tri(1'b1, 12'd4095, 12'd4094, 12'd4093, 4'hF, 4'hE, 4'h1,
                   32'h7FFF_8000, 32'hC000_3FFF, 32'h0800_0800));
    offer(make_tri(1'b0, 12'd4093, 12'd4095, 12'd1, 4'h7, 4'hB, 4'hC,
                   32'h1, 32'h2, 32'h3));
    offer(make_tri(1'b0, 12'd1, 12'd1, 12'd4094, 4'h0, 4'h0, 4'h0,
                   32'h1111_1111, 32'h2222_2222, 32'h3333_3333));
    offer(make_tri(1'b1, 12'd100, 12'd200, 12'd100, 4'h0, 4'hF, 4'h0,
                   32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    wait_drained();

    // random, sender idles rarely, receiver often; one long hold-off fills
    // the core so it stalls its input
    for (int i = 0; i < 84; i++)
      offer(make_random_tri(1'b0));
    hold_req = 1'b1;
    wait_drained();

    // random, roles swapped
    send_idle_pct  = 66;
    recv_stall_pct = 18;
    for (int i = 0; i < 75; i++)
      offer(make_random_tri(1'b0));
    wait_drained();

    // no idling: back-to-back triangles with frequent surface starts
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 75; i++)
      offer(make_random_tri(i % 8 == 0));
    wait_drained();

    repeat (END_CYCLES) @(posedge clk);
  endtask

  initial begin
    fork
      run_all();
      begin
        while (quiet_cycles < QUIET_LIMIT)
          @(negedge clk);
        timed_out = 1'b1;
        $display("%0t watchdog: no item moved for %0d cycles", $time, QUIET_LIMIT);
      end
    join_any
    if (expected_corners.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time,
               expected_corners.size());
      mismatches++;
    end
    $display("run: %0d triangles (%0d kept, %0d culled), %0d surface starts",
             tris_accepted, kept_tris, culled_tris, surface_starts);
    $display("run: %0d corner results checked, %0d new vertices, %0d mismatches",
             corners_checked, new_vertices, mismatches);
    if (!timed_out && mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tcvc_pkg.sv
src/tcvc_ram.sv
src/tcvc_issue.sv
src/tcvc_resolve.sv
src/tcvc_outq.sv
src/triangle_cull_vertex_compactor_core.sv
src/tcvc_checker.sv
tb/sv/tb.sv
